// File: sv/bilinear_grid_upsampler_unit_assert.svh
// ---------------------------------------------------------------------------
// Bilinear grid upsampler assertion macros
// Shared concurrent checks, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_GRID_UPSAMPLER_UNIT_ASSERT_SVH
`define BILINEAR_GRID_UPSAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BGU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bilinear grid upsampler: check failed");

// Next-cycle implication.
`define BGU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bilinear grid upsampler: check failed");

`endif

// File: sv/bgu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear grid upsampler package
// Sizes, register indexes, state types and reciprocal tables.
// ---------------------------------------------------------------------------
package bgu_pkg;

    localparam int MAX_COLS = 4096;
    localparam int MAX_ROWS = 4096;
    localparam int MAX_RATE = 7;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int CCNT_W  = $clog2(MAX_COLS + 1);
    localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
    localparam int RATE_W  = 3;
    localparam int CFG_W   = 13;
    localparam int CIDX_W  = 2;
    localparam int SAMP_W  = 16;
    localparam int COORD_W = 15;
    localparam int WGT_W   = 6;
    localparam int PROD_W  = SAMP_W + WGT_W + 1;
    localparam int NUM_W   = PROD_W + 2;
    localparam int MAG_W   = 21;
    localparam int RCP_SH  = 28;
    localparam int RCP_W   = RCP_SH + 1;
    localparam int QPROD_W = MAG_W + RCP_W;

    localparam logic [CIDX_W-1:0] REG_RATE = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_COLS = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] REG_ROWS = CIDX_W'(2);

    localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(2);
    localparam logic [CFG_W-1:0]  COLS_RST = CFG_W'(4096);
    localparam logic [CFG_W-1:0]  ROWS_RST = CFG_W'(4096);

    typedef logic signed [SAMP_W-1:0] t_sample;
    typedef logic [COORD_W-1:0]       t_coord;
    typedef logic [WGT_W-1:0]         t_weight;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GEN
    } t_state;

    typedef enum logic [1:0] {
        PH_CELL,
        PH_COL,
        PH_ROW,
        PH_CORNER
    } t_phase;

    // ceil(2^28 / rate^2): exact quotient for magnitudes below 2^21.
    function automatic logic [RCP_W-1:0] recip_cell(input logic [RATE_W-1:0] rate);
        logic [RCP_W-1:0] m;
        unique case (rate)
            3'd2:    m = RCP_W'(67108864);
            3'd3:    m = RCP_W'(29826162);
            3'd4:    m = RCP_W'(16777216);
            3'd5:    m = RCP_W'(10737419);
            3'd6:    m = RCP_W'(7456541);
            3'd7:    m = RCP_W'(5478275);
            default: m = RCP_W'(268435456);
        endcase
        return m;
    endfunction

    // ceil(2^28 / rate).
    function automatic logic [RCP_W-1:0] recip_seg(input logic [RATE_W-1:0] rate);
        logic [RCP_W-1:0] m;
        unique case (rate)
            3'd2:    m = RCP_W'(134217728);
            3'd3:    m = RCP_W'(89478486);
            3'd4:    m = RCP_W'(67108864);
            3'd5:    m = RCP_W'(53687092);
            3'd6:    m = RCP_W'(44739243);
            3'd7:    m = RCP_W'(38347923);
            default: m = RCP_W'(268435456);
        endcase
        return m;
    endfunction

endpackage

// File: sv/bilinear_grid_upsampler_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear grid upsampler
// Raster-order grid samples in, rate x rate bilinear points out.
// ---------------------------------------------------------------------------
// Samples arrive in raster order over a valid/ready channel; each beat that
// closes a grid cell produces that cell's rate*rate points (row offset outer,
// column offset inner), then at the last column the rate points of the column
// segment above, on the last row the rate points of the row segment to the
// left, and at the very last sample the corner itself. o_last marks the final
// point caused by one input beat; beats on the first row (other than the last
// row) produce nothing. Every value is the exact rational interpolation,
// truncated toward zero. An input beat holds the block through the row
// store read, the load and the walk over its points; the single point
// generator issues one point per cycle while the output is not stalled.
// Points leave through a four-stage pipeline (products, sum, reciprocal
// multiply, output register), so the next beat is taken while earlier
// points drain. The row store (one 16-bit entry per column) has no clearing
// pass and needs none: within a frame each entry is written before a value
// read from it is used. A register write restarts the frame at row 0,
// column 0; write registers only while the block is idle.
// ---------------------------------------------------------------------------
`include "bilinear_grid_upsampler_unit_assert.svh"

module bilinear_grid_upsampler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [bgu_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [bgu_pkg::CFG_W-1:0]     i_cfg_data,
    // sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [15:0]            i_sample,
    // point channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [14:0]                   o_out_row,
    output logic [14:0]                   o_out_col,
    output logic signed [15:0]            o_height,
    output logic                          o_last
);
    import bgu_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers and effective values
    // ------------------------------------------------------------------
    logic [RATE_W-1:0] r_rate;
    logic [CFG_W-1:0]  r_cols;
    logic [CFG_W-1:0]  r_rows;
    logic [RATE_W-1:0] rate_eff;
    logic [RATE_W-1:0] rate_m1;
    logic [CCNT_W-1:0] cols_eff;
    logic [RCNT_W-1:0] rows_eff;
    logic              cfg_hit;

    always_comb begin
        // Rate zero acts as one; the 3-bit field never exceeds the maximum.
        rate_eff = (r_rate == '0) ? RATE_W'(1) : r_rate;
        rate_m1  = rate_eff - RATE_W'(1);
        if (r_cols == '0) begin
            cols_eff = CCNT_W'(1);
        end else if (r_cols > CFG_W'(MAX_COLS)) begin
            cols_eff = CCNT_W'(MAX_COLS);
        end else begin
            cols_eff = CCNT_W'(r_cols);
        end
        if (r_rows == '0) begin
            rows_eff = RCNT_W'(1);
        end else if (r_rows > CFG_W'(MAX_ROWS)) begin
            rows_eff = RCNT_W'(MAX_ROWS);
        end else begin
            rows_eff = RCNT_W'(r_rows);
        end
    end

    always_comb begin
        unique case (i_cfg_index) inside
            REG_RATE, REG_COLS, REG_ROWS: cfg_hit = i_cfg_we;
            default:                      cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RST;
            r_cols <= COLS_RST;
            r_rows <= ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RATE: r_rate <= i_cfg_data[RATE_W-1:0];
                REG_COLS: r_cols <= i_cfg_data;
                REG_ROWS: r_rows <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    t_phase r_phase;
    t_phase n_phase;
    logic [RATE_W-1:0] r_ofs_a;
    logic [RATE_W-1:0] r_ofs_b;
    logic [RATE_W-1:0] n_ofs_a;
    logic [RATE_W-1:0] n_ofs_b;
    logic r_en_col, r_en_row, r_en_corner;

    logic [ROW_W-1:0] r_row_idx;
    logic [COL_W-1:0] r_col_idx;
    t_sample          r_ul;
    t_sample          r_lf;

    // current item
    t_sample r_in_sample;
    t_sample r_x_ul, r_x_up, r_x_lf, r_x_s;
    t_coord  r_rb_cur, r_rb_prev, r_cb_cur, r_cb_prev;

    // pipeline enable: advance whenever the output register can take a point
    logic pipe_en;
    logic in_fire;
    logic gen_fire;
    logic is_load;

    // ------------------------------------------------------------------
    // Row store: one entry per column, read at accept, written at load
    // ------------------------------------------------------------------
    t_sample r_row_mem [MAX_COLS];
    t_sample r_mem_q;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mem_q <= r_row_mem[r_col_idx];
        end
        if (is_load) begin
            r_row_mem[r_col_idx] <= r_in_sample;
        end
    end

    // ------------------------------------------------------------------
    // Load-time decode of the position
    // ------------------------------------------------------------------
    logic   ld_r_ge1, ld_c_ge1, ld_last_col, ld_last_row;
    logic   ld_cell, ld_col, ld_row, ld_corner, ld_any;
    t_phase ld_phase;
    t_coord ld_rb_cur, ld_cb_cur;

    always_comb begin
        ld_r_ge1    = (r_row_idx != '0);
        ld_c_ge1    = (r_col_idx != '0);
        ld_last_col = ((CCNT_W'(r_col_idx) + CCNT_W'(1)) == cols_eff);
        ld_last_row = ((RCNT_W'(r_row_idx) + RCNT_W'(1)) == rows_eff);
        ld_cell     = ld_r_ge1 && ld_c_ge1;
        ld_col      = ld_r_ge1 && ld_last_col;
        ld_row      = ld_last_row && ld_c_ge1;
        ld_corner   = ld_last_row && ld_last_col;
        ld_any      = ld_cell || ld_col || ld_row || ld_corner;
        if (ld_cell) begin
            ld_phase = PH_CELL;
        end else if (ld_col) begin
            ld_phase = PH_COL;
        end else if (ld_row) begin
            ld_phase = PH_ROW;
        end else begin
            ld_phase = PH_CORNER;
        end
        ld_rb_cur = COORD_W'((ROW_W + RATE_W)'(rate_eff) * (ROW_W + RATE_W)'(r_row_idx));
        ld_cb_cur = COORD_W'((COL_W + RATE_W)'(rate_eff) * (COL_W + RATE_W)'(r_col_idx));
    end

    // ------------------------------------------------------------------
    // Point generator: weights, coordinates, phase walk
    // ------------------------------------------------------------------
    logic [RATE_W-1:0] ra, rb;
    t_weight w_ul, w_up, w_lf, w_s;
    t_coord  pt_row, pt_col;
    logic    pt_seg;
    logic    ph_end;
    logic    later;
    t_phase  ph_next;

    always_comb begin
        ra     = rate_eff - r_ofs_a;
        rb     = rate_eff - r_ofs_b;
        w_ul   = '0;
        w_up   = '0;
        w_lf   = '0;
        w_s    = '0;
        pt_row = r_rb_cur;
        pt_col = r_cb_cur;
        pt_seg = 1'b1;
        ph_end = 1'b1;
        later  = 1'b0;
        unique case (r_phase)
            PH_CELL: begin
                w_ul   = WGT_W'(ra) * WGT_W'(rb);
                w_up   = WGT_W'(ra) * WGT_W'(r_ofs_b);
                w_lf   = WGT_W'(r_ofs_a) * WGT_W'(rb);
                w_s    = WGT_W'(r_ofs_a) * WGT_W'(r_ofs_b);
                pt_row = r_rb_prev + COORD_W'(r_ofs_a);
                pt_col = r_cb_prev + COORD_W'(r_ofs_b);
                pt_seg = 1'b0;
                ph_end = (r_ofs_a == rate_m1) && (r_ofs_b == rate_m1);
                later  = r_en_col || r_en_row || r_en_corner;
            end
            PH_COL: begin
                w_up   = WGT_W'(ra);
                w_s    = WGT_W'(r_ofs_a);
                pt_row = r_rb_prev + COORD_W'(r_ofs_a);
                ph_end = (r_ofs_a == rate_m1);
                later  = r_en_row || r_en_corner;
            end
            PH_ROW: begin
                w_lf   = WGT_W'(rb);
                w_s    = WGT_W'(r_ofs_b);
                pt_col = r_cb_prev + COORD_W'(r_ofs_b);
                ph_end = (r_ofs_b == rate_m1);
                later  = r_en_corner;
            end
            PH_CORNER: begin
                // rate * s over rate gives the sample itself
                w_s    = WGT_W'(rate_eff);
            end
            default: ;
        endcase
        // skip phases that this position does not produce
        if ((r_phase == PH_CELL) && r_en_col) begin
            ph_next = PH_COL;
        end else if (((r_phase == PH_CELL) || (r_phase == PH_COL)) && r_en_row) begin
            ph_next = PH_ROW;
        end else begin
            ph_next = PH_CORNER;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_LOAD;
            ST_LOAD: n_state = ld_any ? ST_GEN : ST_IDLE;
            ST_GEN:  if (pipe_en && ph_end && !later) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_in_ready = 1'b0;
        is_load    = 1'b0;
        gen_fire   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_LOAD: is_load    = 1'b1;
            ST_GEN:  gen_fire   = pipe_en;
            default: ;
        endcase
        in_fire = i_in_valid && o_in_ready;
    end

    // counter walk
    always_comb begin
        n_phase = r_phase;
        n_ofs_a = r_ofs_a;
        n_ofs_b = r_ofs_b;
        if (is_load) begin
            n_phase = ld_phase;
            n_ofs_a = '0;
            n_ofs_b = '0;
        end else if (gen_fire) begin
            if (ph_end) begin
                n_phase = ph_next;
                n_ofs_a = '0;
                n_ofs_b = '0;
            end else begin
                case (r_phase)
                    PH_CELL: begin
                        if (r_ofs_b == rate_m1) begin
                            n_ofs_b = '0;
                            n_ofs_a = r_ofs_a + RATE_W'(1);
                        end else begin
                            n_ofs_b = r_ofs_b + RATE_W'(1);
                        end
                    end
                    PH_COL:  n_ofs_a = r_ofs_a + RATE_W'(1);
                    default: n_ofs_b = r_ofs_b + RATE_W'(1);
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_CELL;
            r_ofs_a <= '0;
            r_ofs_b <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_ofs_a <= n_ofs_a;
            r_ofs_b <= n_ofs_b;
        end
    end

    // position and neighbor samples; any register write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_idx   <= '0;
            r_col_idx   <= '0;
            r_ul        <= '0;
            r_lf        <= '0;
            r_en_col    <= 1'b0;
            r_en_row    <= 1'b0;
            r_en_corner <= 1'b0;
        end else if (cfg_hit) begin
            r_row_idx <= '0;
            r_col_idx <= '0;
            r_ul      <= '0;
            r_lf      <= '0;
        end else if (is_load) begin
            r_ul        <= r_mem_q;
            r_lf        <= r_in_sample;
            r_en_col    <= ld_col;
            r_en_row    <= ld_row;
            r_en_corner <= ld_corner;
            if (ld_last_col) begin
                r_col_idx <= '0;
                r_row_idx <= ld_last_row ? '0 : r_row_idx + ROW_W'(1);
            end else begin
                r_col_idx <= r_col_idx + COL_W'(1);
            end
        end
    end

    // item payload: hold the four corners and coordinate bases for the walk
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_sample <= i_sample;
        end
        if (is_load) begin
            // Drop the corners this position never weights: on the first row
            // they come from row store entries not yet written in this frame.
            r_x_ul    <= ld_cell ? r_ul : '0;
            r_x_up    <= (ld_cell || ld_col) ? r_mem_q : '0;
            r_x_lf    <= r_lf;
            r_x_s     <= r_in_sample;
            r_rb_cur  <= ld_rb_cur;
            r_rb_prev <= ld_rb_cur - COORD_W'(rate_eff);
            r_cb_cur  <= ld_cb_cur;
            r_cb_prev <= ld_cb_cur - COORD_W'(rate_eff);
        end
    end

    // ------------------------------------------------------------------
    // Point pipeline: products -> sum -> reciprocal multiply -> output
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v, r_out_v;
    logic signed [PROD_W-1:0] r_s1_p0, r_s1_p1, r_s1_p2, r_s1_p3;
    t_coord r_s1_row, r_s1_col, r_s2_row, r_s2_col, r_s3_row, r_s3_col;
    logic   r_s1_seg, r_s2_seg, r_s1_last, r_s2_last, r_s3_last;
    logic signed [NUM_W-1:0] r_s2_num;
    logic [QPROD_W-1:0]      r_s3_prod;
    logic                    r_s3_neg;
    t_coord                  r_out_row, r_out_col;
    t_sample                 r_out_h;
    logic                    r_out_last;

    logic signed [NUM_W-1:0] s2_num_abs;
    logic [MAG_W-1:0]        s2_mag;
    logic [RCP_W-1:0]        s2_rcp;
    logic [SAMP_W-1:0]       s3_q;

    assign pipe_en = !r_out_v || i_out_ready;

    always_comb begin
        s2_num_abs = r_s2_num[NUM_W-1] ? -r_s2_num : r_s2_num;
        s2_mag     = s2_num_abs[MAG_W-1:0];
        s2_rcp     = r_s2_seg ? recip_seg(rate_eff) : recip_cell(rate_eff);
        s3_q       = r_s3_prod[RCP_SH +: SAMP_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (pipe_en) begin
            r_s1_v  <= gen_fire;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_p0   <= r_x_ul * $signed({1'b0, w_ul});
            r_s1_p1   <= r_x_up * $signed({1'b0, w_up});
            r_s1_p2   <= r_x_lf * $signed({1'b0, w_lf});
            r_s1_p3   <= r_x_s  * $signed({1'b0, w_s});
            r_s1_row  <= pt_row;
            r_s1_col  <= pt_col;
            r_s1_seg  <= pt_seg;
            r_s1_last <= ph_end && !later;

            r_s2_num  <= NUM_W'(r_s1_p0) + NUM_W'(r_s1_p1)
                       + NUM_W'(r_s1_p2) + NUM_W'(r_s1_p3);
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
            r_s2_seg  <= r_s1_seg;
            r_s2_last <= r_s1_last;

            r_s3_prod <= QPROD_W'(s2_mag) * QPROD_W'(s2_rcp);
            r_s3_neg  <= r_s2_num[NUM_W-1];
            r_s3_row  <= r_s2_row;
            r_s3_col  <= r_s2_col;
            r_s3_last <= r_s2_last;

            // truncate toward zero: divide the magnitude, restore the sign
            r_out_h    <= r_s3_neg ? $signed(-s3_q) : $signed(s3_q);
            r_out_row  <= r_s3_row;
            r_out_col  <= r_s3_col;
            r_out_last <= r_s3_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_height    = r_out_h;
    assign o_last      = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BGU_ASSERT_IMP(a_col_in_grid, 1'b1, CCNT_W'(r_col_idx) < cols_eff)
    `BGU_ASSERT_IMP(a_row_in_grid, 1'b1, RCNT_W'(r_row_idx) < rows_eff)
    `BGU_ASSERT_IMP(a_walk_in_range, r_state == ST_GEN, (r_ofs_a <= rate_m1) && (r_ofs_b <= rate_m1))
    `BGU_ASSERT_NXT(a_accept_loads, in_fire, r_state == ST_LOAD)

endmodule
